### rtl/wave_table_sound_channel_top_macros.svh
// Assertion macros shared by the wave-table sound channel RTL.
// Expects signals named clk and rst in the including module.
`ifndef WAVE_TABLE_SOUND_CHANNEL_TOP_MACROS_SVH
`define WAVE_TABLE_SOUND_CHANNEL_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define WTSC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wtsc check failed");

// next-cycle implication, disabled in reset
`define WTSC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wtsc check failed");

`endif

### rtl/wtsc_pkg.sv
// Package for the wave-table sound channel: item kinds, register addresses,
// volume shift table and the result struct. No dependencies.
`timescale 1ns / 1ps

package wtsc_pkg;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_LEN   = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;
  localparam logic [1:0] MODE_WRITE = 2'd3;

  localparam logic [15:0] ADDR_NR30 = 16'hFF1A;
  localparam logic [15:0] ADDR_NR31 = 16'hFF1B;
  localparam logic [15:0] ADDR_NR32 = 16'hFF1C;
  localparam logic [15:0] ADDR_NR33 = 16'hFF1D;
  localparam logic [15:0] ADDR_NR34 = 16'hFF1E;
  localparam logic [11:0] WAVE_PAGE = 12'hFF3;

  localparam logic [11:0] PERIOD_BASE = 12'd2048;
  localparam logic [8:0]  LEN_FULL    = 9'd256;

  localparam logic [2:0] VOL_SHIFT [4] = '{3'd4, 3'd0, 3'd1, 3'd2};

  typedef struct packed {
    logic [7:0] read_data;
    logic [3:0] sample_out;
    logic       active;
  } wtsc_result_t;

endpackage

### rtl/wtsc_core.sv
// Channel state and per-beat update logic for the wave-table sound channel.
// Depends on wtsc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "wave_table_sound_channel_top_macros.svh"

module wtsc_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [1:0]           mode,
  input  logic [15:0]          address,
  input  logic [7:0]           write_data,
  input  logic                 odd_phase,
  output wtsc_pkg::wtsc_result_t result
);
  import wtsc_pkg::*;

  logic        channel_on, channel_on_next;
  logic        dac_on, dac_on_next;
  logic [8:0]  length_left, length_left_next;
  logic        length_on, length_on_next;
  logic [10:0] period, period_next;
  logic [12:0] divider, divider_next;
  logic [4:0]  position, position_next;
  logic [3:0]  current_nibble, current_nibble_next;
  logic        fetch_hold, fetch_hold_next;
  logic [1:0]  level, level_next;
  logic [3:0]  held_sample, held_sample_next;
  logic [7:0]  wave_ram [16];
  logic [7:0]  wave_ram_next [16];
  logic [7:0]  read_data;

  logic        in_wave;
  logic [3:0]  play_byte;
  logic [4:0]  pos_inc;
  logic [7:0]  fetch_byte;
  logic [12:0] div_dec;
  logic [11:0] span;
  logic [1:0]  grp;

  assign in_wave   = (address[15:4] == WAVE_PAGE);
  assign play_byte = position[4:1];
  assign pos_inc   = position + 5'd1;
  assign fetch_byte = wave_ram[pos_inc[4:1]];
  assign div_dec   = divider - 13'd1;
  assign grp       = play_byte[3:2];

  always_comb begin
    channel_on_next     = channel_on;
    dac_on_next         = dac_on;
    length_left_next    = length_left;
    length_on_next      = length_on;
    period_next         = period;
    divider_next        = divider;
    position_next       = position;
    current_nibble_next = current_nibble;
    fetch_hold_next     = fetch_hold;
    level_next          = level;
    held_sample_next    = held_sample;
    wave_ram_next       = wave_ram;
    read_data           = 8'hFF;
    span                = PERIOD_BASE - {1'b0, period};

    unique case (mode)
      MODE_TICK: begin
        fetch_hold_next = 1'b0;
        divider_next    = div_dec;
        if (div_dec == 13'd0) begin
          divider_next        = {span, 1'b0};
          position_next       = pos_inc;
          current_nibble_next = pos_inc[0] ? fetch_byte[3:0] : fetch_byte[7:4];
          fetch_hold_next     = 1'b1;
        end
        held_sample_next = channel_on ?
                           (current_nibble_next >> VOL_SHIFT[level]) : 4'd0;
      end
      MODE_LEN: begin
        if (length_on && length_left != 9'd0) begin
          length_left_next = length_left - 9'd1;
          if (length_left_next == 9'd0) channel_on_next = 1'b0;
        end
      end
      MODE_READ: begin
        if (address == ADDR_NR30) begin
          read_data = {dac_on, 7'h7F};
        end else if (address == ADDR_NR32) begin
          read_data = {1'b1, level, 5'h1F};
        end else if (address == ADDR_NR34) begin
          read_data = {1'b1, length_on, 6'h3F};
        end else if (in_wave) begin
          if (channel_on) begin
            read_data = fetch_hold ? wave_ram[play_byte] : 8'hFF;
          end else begin
            read_data = wave_ram[address[3:0]];
          end
        end
      end
      MODE_WRITE: begin
        if (address == ADDR_NR30) begin
          dac_on_next = write_data[7];
          if (!write_data[7]) channel_on_next = 1'b0;
        end else if (address == ADDR_NR31) begin
          length_left_next = LEN_FULL - {1'b0, write_data};
        end else if (address == ADDR_NR32) begin
          level_next = write_data[6:5];
        end else if (address == ADDR_NR33) begin
          period_next = {period[10:8], write_data};
        end else if (address == ADDR_NR34) begin
          // extra length clock when length is enabled on an odd phase
          if (odd_phase && !length_on && write_data[6] && length_left != 9'd0) begin
            length_left_next = length_left - 9'd1;
            if (length_left_next == 9'd0) channel_on_next = 1'b0;
          end
          length_on_next = write_data[6];
          period_next    = {write_data[2:0], period[7:0]};
          if (write_data[7]) begin
            if (fetch_hold) begin
              if (grp == 2'd0) begin
                wave_ram_next[0] = wave_ram[play_byte];
              end else begin
                for (int i = 0; i < 4; i++) begin
                  wave_ram_next[i] = wave_ram[{grp, 2'(i)}];
                end
              end
            end
            span                = PERIOD_BASE - {1'b0, period_next};
            channel_on_next     = dac_on;
            divider_next        = {span, 1'b0};
            fetch_hold_next     = 1'b0;
            position_next       = 5'd0;
            current_nibble_next = 4'd0;
            if (length_left_next == 9'd0) begin
              length_left_next = (odd_phase && write_data[6]) ? (LEN_FULL - 9'd1) : LEN_FULL;
            end
          end
        end else if (in_wave) begin
          if (channel_on) begin
            if (fetch_hold) wave_ram_next[play_byte] = write_data;
          end else begin
            wave_ram_next[address[3:0]] = write_data;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_on     <= 1'b0;
      dac_on         <= 1'b0;
      length_left    <= LEN_FULL;
      length_on      <= 1'b0;
      period         <= '0;
      divider        <= '0;
      position       <= '0;
      current_nibble <= '0;
      fetch_hold     <= 1'b0;
      level          <= '0;
      held_sample    <= '0;
      for (int i = 0; i < 16; i++) wave_ram[i] <= 8'h00;
    end else if (accept) begin
      channel_on     <= channel_on_next;
      dac_on         <= dac_on_next;
      length_left    <= length_left_next;
      length_on      <= length_on_next;
      period         <= period_next;
      divider        <= divider_next;
      position       <= position_next;
      current_nibble <= current_nibble_next;
      fetch_hold     <= fetch_hold_next;
      level          <= level_next;
      held_sample    <= held_sample_next;
      wave_ram       <= wave_ram_next;
    end
  end

  assign result.read_data  = read_data;
  assign result.sample_out = held_sample_next;
  assign result.active     = channel_on_next;

  `WTSC_ASSERT_IMP(a_on_needs_dac, channel_on, dac_on)
  `WTSC_ASSERT_IMP(a_len_bound, 1'b1, length_left <= LEN_FULL)
  `WTSC_ASSERT_NXT(a_fetch_on_wrap, accept && mode == MODE_TICK && divider == 13'd1,
                   fetch_hold && divider == $past({span, 1'b0}))

endmodule

### rtl/wave_table_sound_channel_top.sv
// Top level of the wave-table sound channel: stream handshake and result register.
// Depends on wtsc_pkg, wtsc_core and the assertion macro header.
`timescale 1ns / 1ps
`include "wave_table_sound_channel_top_macros.svh"

// Each input beat (tick, length clock, register read or write) is handled in
// the cycle it is accepted and yields exactly one result beat in the output
// register on the next cycle. One beat per cycle is sustained; the input
// stalls only while a result sits in the output register and the sink holds
// tready low. Wave RAM and all channel state are cleared by reset.
module wave_table_sound_channel_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // address[15:0], write_data[23:16], odd_phase[24], zero
  input  logic [1:0]  s_tuser,   // mode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // read_data[7:0], sample_out[11:8], active[12], zero
);
  import wtsc_pkg::*;

  logic         accept;
  wtsc_result_t result;
  wtsc_result_t out_reg;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  wtsc_core u_core (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .mode       (s_tuser),
    .address    (s_tdata[15:0]),
    .write_data (s_tdata[23:16]),
    .odd_phase  (s_tdata[24]),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) out_reg <= result;
  end

  assign m_tdata = {3'b000, out_reg.active, out_reg.sample_out, out_reg.read_data};

  `WTSC_ASSERT_NXT(a_out_from_accept, !m_tvalid, m_tvalid == $past(accept))

endmodule
